// File: rtl/assert_macros.svh
// assertion macros used by the allocator controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dpia_pkg.sv
// shared types and constants of the dual pool index allocator
`timescale 1ns / 1ps

package dpia_pkg;

    localparam int OPCODE_W  = 1;
    localparam int SELECT_W  = 1;
    localparam int RELEASE_W = 7;
    localparam int GRANT_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int NUM_POOLS = 2;

    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd2;

    typedef struct packed {
        logic accept;
        logic load;
    } dpia_cmd_t;

endpackage

// File: rtl/dpia_if.sv
// request and response channel interfaces of the allocator
`timescale 1ns / 1ps

interface dpia_req_if;
    logic                           valid;
    logic                           ready;
    logic [dpia_pkg::OPCODE_W-1:0]  opcode;
    logic [dpia_pkg::SELECT_W-1:0]  pool_select;
    logic [dpia_pkg::RELEASE_W-1:0] release_value;

    modport source (output valid, output opcode, output pool_select, output release_value,
                    input ready);
    modport sink (input valid, input opcode, input pool_select, input release_value,
                  output ready);
endinterface

interface dpia_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dpia_pkg::GRANT_W-1:0]  granted_value;
    logic [dpia_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_value, output status, input ready);
    modport sink (input valid, input granted_value, input status, output ready);
endinterface

// File: rtl/dpia_ctrl.sv
// controller state machine of the allocator
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpia_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dpia_pkg::dpia_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.accept     = 1'b0;
        cmd.load       = 1'b0;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // output word register free or being emptied this cycle
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_accept_to_result, clk, rst_n, cmd.accept, state_reg == S_RESULT, "accepted word did not move to result state")
    `ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load, out_valid_reg, "loaded result not presented")
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, (state_reg == S_RESULT) && out_valid_reg && !rsp_ready, state_reg == S_RESULT, "pending result dropped while output stalled")

endmodule

// File: rtl/dpia_datapath.sv
// pool registers, free-number memory and result registers of the allocator
`timescale 1ns / 1ps

module dpia_datapath #(
    parameter int POOL_SIZE = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dpia_pkg::dpia_cmd_t            cmd,
    input  logic [dpia_pkg::OPCODE_W-1:0]  opcode,
    input  logic [dpia_pkg::SELECT_W-1:0]  pool_select,
    input  logic [dpia_pkg::RELEASE_W-1:0] release_value,
    output logic [dpia_pkg::GRANT_W-1:0]   granted_value,
    output logic [dpia_pkg::STATUS_W-1:0]  status
);

    localparam int PTR_W   = $clog2(POOL_SIZE);
    localparam int CNT_W   = $clog2(POOL_SIZE + 1);
    localparam int ADDR_W  = PTR_W + dpia_pkg::SELECT_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int CMP_W   = (CNT_W > dpia_pkg::RELEASE_W) ? CNT_W : dpia_pkg::RELEASE_W;
    localparam int GRANT_W = dpia_pkg::GRANT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_SIZE - 1);

    // per-pool control registers; wrapped marks that every ring entry has been written
    logic [PTR_W-1:0] take_reg    [dpia_pkg::NUM_POOLS];
    logic [PTR_W-1:0] put_reg     [dpia_pkg::NUM_POOLS];
    logic [CNT_W-1:0] in_use_reg  [dpia_pkg::NUM_POOLS];
    logic             wrapped_reg [dpia_pkg::NUM_POOLS];

    logic [GRANT_W-1:0] mem [DEPTH];
    logic [GRANT_W-1:0] rdata_reg;

    logic [dpia_pkg::STATUS_W-1:0] stat_reg;
    logic                          from_mem_reg;
    logic                          grant_reg;
    logic [GRANT_W-1:0]            init_val_reg;
    logic [GRANT_W-1:0]            granted_reg;
    logic [dpia_pkg::STATUS_W-1:0] status_reg;

    logic [PTR_W-1:0]         take_cur, put_cur, take_adv, put_adv;
    logic [CNT_W-1:0]         in_use_cur;
    logic                     wrapped_cur;
    logic                     alloc_ok, release_ok, is_alloc;
    logic [CMP_W-1:0]         value_ext;
    logic [PTR_W+GRANT_W-1:0] take_ext;
    logic [dpia_pkg::STATUS_W-1:0] stat_next;

    assign take_cur    = take_reg[pool_select];
    assign put_cur     = put_reg[pool_select];
    assign in_use_cur  = in_use_reg[pool_select];
    assign wrapped_cur = wrapped_reg[pool_select];
    assign take_adv    = (take_cur == PTR_LAST) ? '0 : take_cur + 1'b1;
    assign put_adv     = (put_cur == PTR_LAST) ? '0 : put_cur + 1'b1;
    assign value_ext   = CMP_W'(release_value);
    assign take_ext    = {{GRANT_W{1'b0}}, take_cur};

    assign is_alloc   = (opcode == dpia_pkg::OP_ALLOC);
    assign alloc_ok   = is_alloc && (in_use_cur < CNT_W'(POOL_SIZE));
    assign release_ok = !is_alloc && (value_ext < CMP_W'(POOL_SIZE)) && (in_use_cur != '0);

    always_comb
    begin
        if (alloc_ok || release_ok)
        begin
            stat_next = dpia_pkg::ST_OK;
        end
        else if (is_alloc)
        begin
            stat_next = dpia_pkg::ST_EXHAUSTED;
        end
        else
        begin
            stat_next = dpia_pkg::ST_REFUSED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < dpia_pkg::NUM_POOLS; p++)
            begin
                take_reg[p]    <= '0;
                put_reg[p]     <= '0;
                in_use_reg[p]  <= '0;
                wrapped_reg[p] <= 1'b0;
            end
        end
        else if (cmd.accept)
        begin
            if (alloc_ok)
            begin
                take_reg[pool_select]   <= take_adv;
                in_use_reg[pool_select] <= in_use_cur + 1'b1;
            end
            else if (release_ok)
            begin
                put_reg[pool_select]    <= put_adv;
                in_use_reg[pool_select] <= in_use_cur - 1'b1;
                if (put_cur == PTR_LAST)
                begin
                    wrapped_reg[pool_select] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && release_ok)
        begin
            mem[{pool_select, put_cur}] <= release_value[GRANT_W-1:0];
        end
        if (cmd.accept && alloc_ok)
        begin
            rdata_reg <= mem[{pool_select, take_cur}];
        end
    end

    // request decision held until the result is loaded
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stat_reg     <= stat_next;
            grant_reg    <= alloc_ok;
            // entries past the put pointer before its first wrap still hold their index
            from_mem_reg <= wrapped_cur || (take_cur < put_cur);
            init_val_reg <= take_ext[GRANT_W-1:0];
        end
        if (cmd.load)
        begin
            status_reg <= stat_reg;
            if (!grant_reg)
            begin
                granted_reg <= '0;
            end
            else if (from_mem_reg)
            begin
                granted_reg <= rdata_reg;
            end
            else
            begin
                granted_reg <= init_val_reg;
            end
        end
    end

    assign granted_value = granted_reg;
    assign status        = status_reg;

endmodule

// File: rtl/dual_pool_index_allocator_core.sv
// Dual pool index allocator: two independent pools of entry numbers 0..POOL_SIZE-1, each a
// ring of free numbers with take and put pointers and an in-use count. An allocate word pops
// the number at the take pointer (status exhausted when all are in use); a release word pushes
// release_value at the put pointer (refused when out of range or nothing is in use). Every
// request word yields one response word. A request is accepted in the idle state and its
// response is loaded into the output register in the result state, which waits while the
// previous response is still held there; no request is taken before that load. Both rings
// live in the free-number memory (2 * 2**clog2(POOL_SIZE) words of 6 bits), which has a
// registered read port. A new request is taken while the previous response still waits on
// the output. No clearing pass runs after reset: unwritten entries read as their own index.
`timescale 1ns / 1ps

module dual_pool_index_allocator_core #(
    parameter int POOL_SIZE = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    dpia_req_if.sink     req,
    dpia_rsp_if.source   rsp
);

    dpia_pkg::dpia_cmd_t cmd;

    dpia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    dpia_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (req.opcode),
        .pool_select   (req.pool_select),
        .release_value (req.release_value),
        .granted_value (rsp.granted_value),
        .status        (rsp.status)
    );

endmodule

// File: test/dual_pool_index_allocator_core_test.sv
// self-checking testbench for the dual pool index allocator core
`timescale 1ns / 1ps

module dual_pool_index_allocator_core_test;

    localparam int POOL_SIZE = 64;
    localparam int RANDOM_ITEMS = 400;

    localparam int OPCODE_W  = dpia_pkg::OPCODE_W;
    localparam int SELECT_W  = dpia_pkg::SELECT_W;
    localparam int RELEASE_W = dpia_pkg::RELEASE_W;
    localparam int GRANT_W   = dpia_pkg::GRANT_W;
    localparam int STATUS_W  = dpia_pkg::STATUS_W;
    localparam int NUM_POOLS = dpia_pkg::NUM_POOLS;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [SELECT_W-1:0]  pool_select;
        logic [RELEASE_W-1:0] release_value;
    } request_t;

    typedef struct packed {
        logic [GRANT_W-1:0]  granted_value;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic clk;
    logic rst_n;

    dpia_req_if req_ch ();
    dpia_rsp_if rsp_ch ();

    dual_pool_index_allocator_core #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // own copy of both pools
    logic [GRANT_W-1:0] free_ring [NUM_POOLS][POOL_SIZE];
    int take_ptr [NUM_POOLS];
    int put_ptr [NUM_POOLS];
    int in_use [NUM_POOLS];

    request_t request_queue[$];
    grant_t   expected_grants[$];

    request_t accepted_req;
    grant_t   oldest_grant;
    int fail_count = 0;
    int results_seen = 0;
    int send_wait = 0;
    int stall_left = 0;
    int hold_left = 0;
    int req_calm = 0;
    int rsp_calm = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void clear_pools();
        for (int p = 0; p < NUM_POOLS; p++)
        begin
            for (int k = 0; k < POOL_SIZE; k++)
                free_ring[p][k] = GRANT_W'(k);
            take_ptr[p] = 0;
            put_ptr[p] = 0;
            in_use[p] = 0;
        end
    endfunction

    function automatic grant_t predict_grant(request_t r);
        grant_t g;
        int p;
        p = int'(r.pool_select);
        g.granted_value = '0;
        g.status = dpia_pkg::ST_OK;
        if (r.opcode == dpia_pkg::OP_ALLOC)
        begin
            if (in_use[p] >= POOL_SIZE)
                g.status = dpia_pkg::ST_EXHAUSTED;
            else
            begin
                g.granted_value = free_ring[p][take_ptr[p]];
                take_ptr[p] = (take_ptr[p] + 1) % POOL_SIZE;
                in_use[p]++;
            end
        end
        else
        begin
            if (int'(r.release_value) >= POOL_SIZE || in_use[p] == 0)
                g.status = dpia_pkg::ST_REFUSED;
            else
            begin
                free_ring[p][put_ptr[p]] = GRANT_W'(r.release_value);
                put_ptr[p] = (put_ptr[p] + 1) % POOL_SIZE;
                in_use[p]--;
            end
        end
        return g;
    endfunction

    // idle cycles before the next word, with occasional runs of back-to-back words
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 9);
    endfunction

    function automatic void add_request(logic [OPCODE_W-1:0] op, logic [SELECT_W-1:0] sel,
                                        logic [RELEASE_W-1:0] val);
        request_t r;
        r.opcode = op;
        r.pool_select = sel;
        r.release_value = val;
        request_queue.push_back(r);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.opcode <= dpia_pkg::OP_ALLOC;
            req_ch.pool_select <= '0;
            req_ch.release_value <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                accepted_req.opcode = req_ch.opcode;
                accepted_req.pool_select = req_ch.pool_select;
                accepted_req.release_value = req_ch.release_value;
                expected_grants.push_back(predict_grant(accepted_req));
            end
            // a word still on offer stays put
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    accepted_req = request_queue.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.opcode <= accepted_req.opcode;
                    req_ch.pool_select <= accepted_req.pool_select;
                    req_ch.release_value <= accepted_req.release_value;
                    send_wait = draw_wait(req_calm);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (expected_grants.size() == 0)
                begin
                    $error("response word with nothing expected: granted_value %0d status %0d",
                           rsp_ch.granted_value, rsp_ch.status);
                    fail_count++;
                end
                else
                begin
                    oldest_grant = expected_grants.pop_front();
                    if (rsp_ch.granted_value !== oldest_grant.granted_value)
                    begin
                        $error("granted_value: expected %0d, actual %0d",
                               oldest_grant.granted_value, rsp_ch.granted_value);
                        fail_count++;
                    end
                    if (rsp_ch.status !== oldest_grant.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_grant.status, rsp_ch.status);
                        fail_count++;
                    end
                end
                stall_left = draw_wait(rsp_calm);
                // long back-pressure so the core fills and stalls its input
                if (results_seen == 120)
                    hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int added;
        int kind;
        int run;
        logic [SELECT_W-1:0] sel;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = dpia_pkg::OP_ALLOC;
        req_ch.pool_select = '0;
        req_ch.release_value = '0;
        rsp_ch.ready = 1'b0;
        clear_pools();

        // directed: refusals on empty pools, range edges, both pools
        add_request(dpia_pkg::OP_RELEASE, 1'b0, 7'd5);
        add_request(dpia_pkg::OP_RELEASE, 1'b1, 7'd0);
        add_request(dpia_pkg::OP_ALLOC, 1'b0, 7'd127);
        add_request(dpia_pkg::OP_ALLOC, 1'b1, 7'd0);
        add_request(dpia_pkg::OP_ALLOC, 1'b0, 7'd0);
        add_request(dpia_pkg::OP_RELEASE, 1'b0, 7'd127);
        add_request(dpia_pkg::OP_RELEASE, 1'b0, 7'd64);
        add_request(dpia_pkg::OP_RELEASE, 1'b0, 7'd63);
        add_request(dpia_pkg::OP_RELEASE, 1'b0, 7'd0);
        add_request(dpia_pkg::OP_RELEASE, 1'b0, 7'd42);
        add_request(dpia_pkg::OP_ALLOC, 1'b0, 7'd0);
        add_request(dpia_pkg::OP_ALLOC, 1'b0, 7'd0);
        add_request(dpia_pkg::OP_RELEASE, 1'b1, 7'd63);
        add_request(dpia_pkg::OP_RELEASE, 1'b1, 7'd1);
        add_request(dpia_pkg::OP_ALLOC, 1'b1, 7'd85);
        add_request(dpia_pkg::OP_RELEASE, 1'b1, 7'd0);
        add_request(dpia_pkg::OP_ALLOC, 1'b1, 7'd0);

        // drain pool a past exhaustion, then refill it past empty
        for (int i = 0; i < 66; i++)
            add_request(dpia_pkg::OP_ALLOC, 1'b0, RELEASE_W'($urandom_range(0, 127)));
        for (int i = 0; i < 66; i++)
            add_request(dpia_pkg::OP_RELEASE, 1'b0, RELEASE_W'($urandom_range(0, 63)));
        added = request_queue.size();

        while (added < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 3);
            run = $urandom_range(1, 70);
            if (run > RANDOM_ITEMS - added)
                run = RANDOM_ITEMS - added;
            sel = SELECT_W'($urandom_range(0, 1));
            for (int i = 0; i < run; i++)
            begin
                case (kind)
                    0: add_request(dpia_pkg::OP_ALLOC, sel,
                                   RELEASE_W'($urandom_range(0, 127)));
                    1: add_request(dpia_pkg::OP_RELEASE, sel, ($urandom_range(0, 9) == 0) ?
                                   RELEASE_W'($urandom_range(64, 127)) :
                                   RELEASE_W'($urandom_range(0, 63)));
                    default: add_request($urandom_range(0, 1) ? dpia_pkg::OP_RELEASE :
                                                                dpia_pkg::OP_ALLOC,
                                         SELECT_W'($urandom_range(0, 1)),
                                         RELEASE_W'($urandom_range(0, 127)));
                endcase
            end
            added += run;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || req_ch.valid || expected_grants.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: dual_pool_index_allocator_core.f
+incdir+rtl
rtl/dpia_pkg.sv
rtl/dpia_if.sv
rtl/dpia_ctrl.sv
rtl/dpia_datapath.sv
rtl/dual_pool_index_allocator_core.sv
test/dual_pool_index_allocator_core_test.sv
